FILE: rtl/lra_pkg.sv
// ----------------------------------------------------------------------------
// lra_pkg
// Shared constants and types for the light range solver: field widths,
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package lra_pkg;

	// default fraction bits of coefficients and distance
	localparam int FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int ATT_W     = 17;
	localparam int ATT_FRAC  = 16;
	localparam int COEF_W    = 32;
	localparam int DIST_W    = 32;
	localparam int CFG_IDX_W = 2;

	// smallest attenuation used, 0.05 in Q1.16
	localparam logic [ATT_W-1:0] ATT_MIN = 17'd3277;

	// register reset values
	localparam logic [COEF_W-1:0] COEF_CONST_RST  = 32'd43691;
	localparam logic [COEF_W-1:0] COEF_LINEAR_RST = 32'd341;
	localparam logic [COEF_W-1:0] COEF_QUAD_RST   = 32'd0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONST  = 2'd0,
		REG_LINEAR = 2'd1,
		REG_QUAD   = 2'd2
	} cfg_reg_t;

endpackage

FILE: rtl/light_range_from_attenuation.sv
// ----------------------------------------------------------------------------
// light_range_from_attenuation
// Solves constant/linear/quadratic light falloff for the distance at which
// a wanted attenuation is reached, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - request channel: req_valid with attenuation (unsigned Q1.16); a request
//    is taken at a clock edge with req_valid high and req_stall low
//  - response channel: rsp_valid with distance, unreachable, overflow; the
//    response is taken when rsp_valid is high and rsp_stall is low
//  - configuration: cfg_valid, cfg_index, cfg_data write coef_const (0),
//    coef_linear (1) and coef_quad (2); cfg_ready is always high, other
//    indexes are ignored; write only while no request is in flight
//  - throughput: one request per cycle while req_stall is low
//  - pipeline: a chain of one-bit-per-stage units: reciprocal divider
//    (FRAC_BITS + 5 stages), square root (34 stages) and distance divider
//    (32 stages)
//  - when the receiver stalls a held response, the whole pipeline freezes
//    and req_stall is raised in the same cycle; nothing is lost
//  - reset empties the pipeline and loads the coefficient reset values
// ----------------------------------------------------------------------------
module light_range_from_attenuation #(
	parameter int FRAC_BITS = lra_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lra_pkg::COEF_W-1:0]     cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [lra_pkg::ATT_W-1:0]      attenuation,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [lra_pkg::DIST_W-1:0]     distance,
	output logic                           unreachable,
	output logic                           overflow
);
	import lra_pkg::*;

	// reciprocal divider widths
	localparam int NRW = FRAC_BITS + ATT_FRAC + 1;
	localparam int RW  = FRAC_BITS + 5;
	localparam int TW  = NRW + RW;
	// constant term minus reciprocal
	localparam int CW  = ((RW + 1 > COEF_W + 1) ? RW + 1 : COEF_W + 1) + 1;
	localparam int CMW = CW - 1;
	// discriminant and square root
	localparam int PW  = (COEF_W - 1) + CMW;
	localparam int BW  = 2 * COEF_W;
	localparam int DW  = ((PW + 2 > BW) ? PW + 2 : BW) + 1;
	localparam int SW  = (DW + 1) / 2;
	localparam int XW  = 2 * SW + 1;
	// distance divider
	localparam int MW  = (SW + 1 > CMW) ? SW + 1 : CMW;
	localparam int NW  = MW + FRAC_BITS;
	localparam int WW  = NW + DIST_W + 1;

	logic adv;

	// configuration registers
	logic [COEF_W-1:0] coef_const_q, coef_linear_q, coef_quad_q;
	logic              quad_on, lin_on;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_const_q  <= COEF_CONST_RST;
			coef_linear_q <= COEF_LINEAR_RST;
			coef_quad_q   <= COEF_QUAD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CONST:  coef_const_q  <= cfg_data;
				REG_LINEAR: coef_linear_q <= cfg_data;
				REG_QUAD:   coef_quad_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// the user must keep coefficients stable while requests are in flight; the block does not enforce this
	assign quad_on = !coef_quad_q[COEF_W-1] && (coef_quad_q != '0);
	assign lin_on  = !coef_linear_q[COEF_W-1] && (coef_linear_q != '0);

	// pipeline advances unless the held response is stalled
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	// input stage: clamp and rounding numerator of the reciprocal
	logic [ATT_W-1:0] att_clamp;
	logic [NRW-1:0]   rcp_rem_s [RW+1];
	logic [RW-1:0]    rcp_q_s   [RW+1];
	logic [ATT_W-1:0] rcp_att_s [RW+1];
	logic             rcp_v_s   [RW+1];

	assign att_clamp = (attenuation < ATT_MIN) ? ATT_MIN : attenuation;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rcp_v_s[0] <= 1'b0;
		else if (adv) rcp_v_s[0] <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rcp_rem_s[0] <= (NRW'(1) << (ATT_FRAC + FRAC_BITS)) + NRW'(att_clamp >> 1);
			rcp_q_s[0]   <= '0;
			rcp_att_s[0] <= att_clamp;
		end
	end

	// reciprocal: restoring division, one quotient bit per stage
	for (genvar j = 0; j < RW; j++) begin : g_rcp
		localparam int K = RW - 1 - j;
		logic [TW-1:0] trial, remx, diff;
		logic          ge;

		assign trial = TW'(rcp_att_s[j]) << K;
		assign remx  = TW'(rcp_rem_s[j]);
		assign ge    = remx >= trial;
		assign diff  = remx - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rcp_v_s[j+1] <= 1'b0;
			else if (adv) rcp_v_s[j+1] <= rcp_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rcp_rem_s[j+1] <= ge ? NRW'(diff) : rcp_rem_s[j];
				rcp_q_s[j+1]   <= rcp_q_s[j] | (ge ? (RW'(1) << K) : RW'(0));
				rcp_att_s[j+1] <= rcp_att_s[j];
			end
		end
	end

	// constant term minus reciprocal
	logic signed [CW-1:0] cval;
	logic                 c_neg_sc, v_sc;
	logic [CMW-1:0]       cmag_sc;

	assign cval = CW'($signed(coef_const_q)) - CW'($signed({1'b0, rcp_q_s[RW]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sc <= 1'b0;
		else if (adv) v_sc <= rcp_v_s[RW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_neg_sc <= cval[CW-1];
			cmag_sc  <= cval[CW-1] ? CMW'(-cval) : CMW'(cval);
		end
	end

	// products a*|c| and b*b
	logic [COEF_W-1:0] bmag;
	logic [PW-1:0]     p_sm;
	logic [BW-1:0]     bsq_sm;
	logic [CMW-1:0]    cmag_sm;
	logic              c_neg_sm, v_sm;

	assign bmag = coef_linear_q[COEF_W-1] ? (~coef_linear_q + 1'b1) : coef_linear_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sm <= 1'b0;
		else if (adv) v_sm <= v_sc;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_sm     <= PW'(coef_quad_q[COEF_W-2:0]) * PW'(cmag_sc);
			bsq_sm   <= BW'(bmag) * BW'(bmag);
			cmag_sm  <= cmag_sc;
			c_neg_sm <= c_neg_sc;
		end
	end

	// discriminant b*b - 4ac and its sign
	logic [DW-1:0] p4, bsqx;
	logic [DW-1:0] sq_rem_s  [SW+1];
	logic [SW-1:0] sq_root_s [SW+1];
	logic [CMW-1:0] sq_cmag_s [SW+1];
	logic          sq_neg_s  [SW+1];
	logic          sq_v_s    [SW+1];

	assign p4   = DW'(p_sm) << 2;
	assign bsqx = DW'(bsq_sm);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else if (adv) sq_v_s[0] <= v_sm;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rem_s[0]  <= c_neg_sm ? (bsqx + p4) : (bsqx - p4);
			sq_neg_s[0]  <= !c_neg_sm && (p4 > bsqx);
			sq_root_s[0] <= '0;
			sq_cmag_s[0] <= cmag_sm;
		end
	end

	// square root: one root bit per stage, remainder kept as d - r*r
	for (genvar j = 0; j < SW; j++) begin : g_sqrt
		localparam int I = SW - 1 - j;
		logic [XW-1:0] trial, remx;
		logic          ge;

		assign trial = (XW'(sq_root_s[j]) << (I + 1)) + (XW'(1) << (2 * I));
		assign remx  = XW'(sq_rem_s[j]);
		assign ge    = remx >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[j+1] <= 1'b0;
			else if (adv) sq_v_s[j+1] <= sq_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[j+1]  <= ge ? DW'(remx - trial) : sq_rem_s[j];
				sq_root_s[j+1] <= sq_root_s[j] | (ge ? (SW'(1) << I) : SW'(0));
				sq_cmag_s[j+1] <= sq_cmag_s[j];
				sq_neg_s[j+1]  <= sq_neg_s[j];
			end
		end
	end

	// numerator and divisor for the quadratic or linear solution
	logic signed [SW+1:0] num;
	logic [MW-1:0]        num_mag;
	logic [NW-1:0]        n_sn;
	logic [DIST_W-1:0]    d_sn;
	logic                 unr_sn, v_sn;

	assign num     = $signed({2'b00, sq_root_s[SW]}) - (SW+2)'($signed(coef_linear_q));
	assign num_mag = num[SW+1] ? MW'(-num) : MW'(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sn <= 1'b0;
		else if (adv) v_sn <= sq_v_s[SW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (quad_on) begin
				n_sn   <= NW'(num_mag) << FRAC_BITS;
				d_sn   <= {coef_quad_q[COEF_W-2:0], 1'b0};
				unr_sn <= sq_neg_s[SW];
			end else begin
				n_sn   <= NW'(sq_cmag_s[SW]) << FRAC_BITS;
				d_sn   <= coef_linear_q;
				unr_sn <= !lin_on;
			end
		end
	end

	// overflow check: quotient of 2^32 or more
	logic [NW-1:0]     dv_rem_s [DIST_W+1];
	logic [DIST_W-1:0] dv_d_s   [DIST_W+1];
	logic [DIST_W-1:0] dv_q_s   [DIST_W+1];
	logic              dv_unr_s [DIST_W+1];
	logic              dv_ovf_s [DIST_W+1];
	logic              dv_v_s   [DIST_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (adv) dv_v_s[0] <= v_sn;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem_s[0] <= n_sn;
			dv_d_s[0]   <= d_sn;
			dv_q_s[0]   <= '0;
			dv_unr_s[0] <= unr_sn;
			dv_ovf_s[0] <= WW'(n_sn) >= (WW'(d_sn) << DIST_W);
		end
	end

	// distance divider: one quotient bit per stage
	for (genvar j = 0; j < DIST_W; j++) begin : g_div
		localparam int K = DIST_W - 1 - j;
		logic [WW-1:0] trial, remx;
		logic          ge;

		assign trial = WW'(dv_d_s[j]) << K;
		assign remx  = WW'(dv_rem_s[j]);
		assign ge    = remx >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (adv) dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[j+1] <= ge ? NW'(remx - trial) : dv_rem_s[j];
				dv_q_s[j+1]   <= dv_q_s[j] | (ge ? (DIST_W'(1) << K) : DIST_W'(0));
				dv_d_s[j+1]   <= dv_d_s[j];
				dv_unr_s[j+1] <= dv_unr_s[j];
				dv_ovf_s[j+1] <= dv_ovf_s[j];
			end
		end
	end

	// response register with saturation
	logic              out_v_q;
	logic [DIST_W-1:0] dist_q;
	logic              unr_q, ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= dv_v_s[DIST_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unr_q  <= dv_unr_s[DIST_W];
			ovf_q  <= !dv_unr_s[DIST_W] && dv_ovf_s[DIST_W];
			dist_q <= (dv_unr_s[DIST_W] || dv_ovf_s[DIST_W]) ? '1 : dv_q_s[DIST_W];
		end
	end

	assign rsp_valid   = out_v_q;
	assign distance    = dist_q;
	assign unreachable = unr_q;
	assign overflow    = ovf_q;

	// checks
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(unreachable && overflow))
		else $error("unreachable and overflow both set");

	a_sat_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (unreachable || overflow)) |-> (distance == '1))
		else $error("flagged response without saturated distance");

	a_rcp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rcp_v_s[RW] |-> (rcp_q_s[RW] != '0))
		else $error("reciprocal came out zero");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with empty response register");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for light_range_from_attenuation: predicts each
// distance from the current coefficients and compares every response in order.
// ----------------------------------------------------------------------------
module tb;
	import lra_pkg::*;

	localparam int F = FRAC_BITS_DEF;
	localparam int LATENCY = F + 78;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              unreachable;
		logic              overflow;
	} range_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [ATT_W-1:0] attenuation = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [DIST_W-1:0] distance;
	logic unreachable;
	logic overflow;

	light_range_from_attenuation u_dut (.*);

	// coefficient shadow
	logic signed [31:0] k_const = 32'sd43691;
	logic signed [31:0] k_linear = 32'sd341;
	logic signed [31:0] k_quad = 32'sd0;

	logic [ATT_W-1:0] att_queue[$];
	range_t expected_ranges[$];
	int errors = 0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit hold_requests = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int quiet_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// exact solver of the falloff equation
	function automatic range_t solve_range(logic [ATT_W-1:0] att_in);
		logic [63:0] att;
		logic [63:0] recip;
		logic signed [65:0] c;
		logic [65:0] cmag;
		logic [63:0] bmag;
		logic [129:0] disc;
		logic [129:0] t4;
		logic [69:0] root;
		logic [69:0] probe;
		logic signed [71:0] num;
		logic [127:0] q;
		range_t r;
		att = (att_in < ATT_MIN) ? 64'(ATT_MIN) : 64'(att_in);
		recip = ((64'd1 << (ATT_FRAC + F)) + att / 2) / att;
		c = 66'(k_const) - $signed({2'b0, recip});
		cmag = (c < 0) ? 66'(-c) : 66'(c);
		bmag = (k_linear < 0) ? 64'(-64'(k_linear)) : 64'(k_linear);
		r = '{distance: '1, unreachable: 1'b1, overflow: 1'b0};
		if (k_quad > 0) begin
			t4 = 130'(k_quad) * 130'(cmag) * 4;
			if (c >= 0 && t4 > 130'(bmag) * 130'(bmag))
				return r;
			disc = (c >= 0) ? 130'(bmag) * 130'(bmag) - t4 : 130'(bmag) * 130'(bmag) + t4;
			root = '0;
			for (int bitpos = 34; bitpos >= 0; bitpos--) begin
				probe = root | (70'd1 << bitpos);
				if (130'(probe) * 130'(probe) <= disc)
					root = probe;
			end
			num = $signed({2'b0, root}) - 72'(k_linear);
			q = (128'(num < 0 ? -num : num) << F) / (128'(k_quad) * 2);
		end else if (k_linear > 0) begin
			q = (128'(cmag) << F) / 128'(k_linear);
		end else begin
			return r;
		end
		r.unreachable = 1'b0;
		if (q > 128'hFFFF_FFFF) begin
			r.distance = '1;
			r.overflow = 1'b1;
		end else begin
			r.distance = q[31:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!(req_valid && req_stall)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (!hold_requests && att_queue.size() > 0) begin
					if (send_idle_on && $urandom_range(0, 15) == 0) begin
						send_gap <= $urandom_range(1, 19);
						req_valid <= 1'b0;
					end else begin
						attenuation <= att_queue.pop_front();
						req_valid <= 1'b1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// prediction at request acceptance
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			expected_ranges.push_back(solve_range(attenuation));
	end

	// response monitor and receiver stall
	always @(posedge clk) begin
		range_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_ranges.size() == 0) begin
					report_mismatch("unexpected response", 64'(distance), 64'd0);
				end else begin
					want = expected_ranges.pop_front();
					if (distance !== want.distance)
						report_mismatch("distance", 64'(distance), 64'(want.distance));
					if (unreachable !== want.unreachable)
						report_mismatch("unreachable", 64'(unreachable),
							64'(want.unreachable));
					if (overflow !== want.overflow)
						report_mismatch("overflow", 64'(overflow), 64'(want.overflow));
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_stall <= 1'b1;
			end else if (recv_idle_on && $urandom_range(0, 15) == 0) begin
				recv_gap <= $urandom_range(0, 18);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic drain;
		wait (att_queue.size() == 0 && !req_valid);
		while (expected_ranges.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_coef(cfg_reg_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CONST: k_const = value;
			REG_LINEAR: k_linear = value;
			REG_QUAD: k_quad = value;
			default: ;
		endcase
		// cfg_valid stays low before the next write
		@(posedge clk);
	endtask

	function automatic logic [31:0] random_coef();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(-$urandom_range(0, 1 << 20));
			3: return $urandom;
			default: return $urandom_range(0, 1 << 20);
		endcase
	endfunction

	function automatic logic [ATT_W-1:0] random_att();
		case ($urandom_range(0, 3))
			0: return 17'($urandom_range(0, 4000));
			1: return 17'($urandom_range(65536, 131071));
			default: return 17'($urandom_range(0, 131071));
		endcase
	endfunction

	initial begin
		logic [31:0] corner[4];
		corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset coefficients, attenuation extremes and clamp edge
		foreach (corner[i]) att_queue.push_back(17'(corner[i]));
		att_queue.push_back(17'd3276);
		att_queue.push_back(17'd3277);
		att_queue.push_back(17'd65536);
		att_queue.push_back(17'h1FFFF);
		att_queue.push_back(17'h0AAAA);
		att_queue.push_back(17'h15555);
		drain();

		// directed: quadratic, negative discriminant, no falloff, far distance
		write_coef(REG_QUAD, 32'd1 << 10);
		write_coef(REG_LINEAR, 32'hFFFF_0000);
		write_coef(REG_CONST, 32'h7FFF_FFFF);
		att_queue.push_back(17'd3277);
		att_queue.push_back(17'h1FFFF);
		drain();
		write_coef(REG_CONST, 32'd0);
		att_queue.push_back(17'd0);
		att_queue.push_back(17'd65536);
		drain();
		write_coef(REG_QUAD, 32'h8000_0000);
		write_coef(REG_LINEAR, 32'h8000_0000);
		att_queue.push_back(17'd40000);
		drain();
		write_coef(REG_QUAD, 32'd0);
		write_coef(REG_LINEAR, 32'd1);
		write_coef(REG_CONST, 32'h8000_0000);
		att_queue.push_back(17'd3277);
		att_queue.push_back(17'h1FFFF);
		drain();

		// random phases with random coefficient sets
		for (int phase = 0; phase < 24; phase++) begin
			write_coef(REG_CONST, random_coef());
			write_coef(REG_LINEAR, random_coef());
			write_coef(REG_QUAD, ($urandom_range(0, 3) == 0) ? random_coef()
				: 32'($urandom_range(0, 1 << 16)));
			if (phase >= 20) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end
			for (int n = 0; n < 50; n++)
				att_queue.push_back(random_att());
			if (phase == 5) begin
				// let the pipeline empty in the middle of a phase
				wait (att_queue.size() < 25);
				hold_requests = 1'b1;
				while (expected_ranges.size() != 0 || req_valid)
					@(posedge clk);
				hold_requests = 1'b0;
			end
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
